[src/tcw_pkg.sv]
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: payload structs,
// controller states, command and status groups, character codes.
// ---------------------------------------------------------------------------
package tcw_pkg;

	localparam int MAX_CELLS = 4096;
	localparam int ADDR_W    = $clog2(MAX_CELLS);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int CELL_W    = 16;
	localparam int COLS_W    = 8;
	localparam int ROWS_W    = 6;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int PROD_W    = COLS_W + ROW_W + 1;
	localparam int CHAR_W    = 8;
	localparam int POS_W     = 12;
	localparam int CELL_A_W  = 12;

	localparam logic [COLS_W-1:0] MAX_COLS     = 8'd128;
	localparam logic [ROWS_W-1:0] MAX_ROWS     = 6'd32;
	localparam logic [COLS_W-1:0] RESET_COLS   = 8'd80;
	localparam logic [ROWS_W-1:0] RESET_ROWS   = 6'd25;
	localparam logic [CELL_W-1:0] TEXT_ATTRIBUTE = 16'h0F00;
	localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0020;

	localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BS = 8'h08;

	localparam logic KIND_PUT  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic CFG_COLUMNS = 1'b0;
	localparam logic CFG_ROWS    = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [CHAR_W-1:0]   char_code;
		logic [CELL_A_W-1:0] cell_address;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_position;
		logic [CELL_W-1:0] cell_data;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic clr_step;
		logic scroll_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic scroll_req;
		logic scroll_last;
	} sts_t;

endpackage

[src/tcw_datapath.sv]
// ---------------------------------------------------------------------------
// tcw_datapath
// Cell store, cursor and configuration registers, scroll copy pipeline and
// result register, driven by commands from the controller.
// ---------------------------------------------------------------------------
module tcw_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [tcw_pkg::COLS_W-1:0] cfg_data,
	input  tcw_pkg::req_t              req,
	input  tcw_pkg::cmd_t              cmd,
	output tcw_pkg::sts_t              sts,
	output tcw_pkg::rsp_t              rsp
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem [MAX_CELLS];
	logic [CELL_W-1:0] rdata_q;

	logic [COLS_W-1:0] columns_q;
	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] c_eff;
	logic [ROWS_W-1:0] r_eff;

	req_t              item_q;
	rsp_t              rsp_q;
	logic [COL_W-1:0]  col_q, col_d, col_sat;
	logic [ROW_W-1:0]  row_q, row_d, row_sat, nr_row;
	logic [ROWS_W-1:0] row_inc;
	logic [COLS_W-1:0] col_inc;
	logic              row_wrap, col_wrap, scroll_req, chr_we;

	logic [PROD_W-1:0] wr_sum, pos_sum;
	logic [ADDR_W-1:0] wr_pos;

	logic [CNT_W-1:0]  ptr_q, total_q, src;
	logic              issue;
	logic              wv_s1, copy_s1;
	logic [ADDR_W-1:0] waddr_s1;

	logic              re, we;
	logic [ADDR_W-1:0] raddr, waddr;
	logic [CELL_W-1:0] wdata;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= RESET_COLS;
			rows_q    <= RESET_ROWS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLUMNS: columns_q <= cfg_data;
				CFG_ROWS:    rows_q    <= cfg_data[ROWS_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		if (columns_q == '0)
			c_eff = COLS_W'(1);
		else if (columns_q > MAX_COLS)
			c_eff = MAX_COLS;
		else
			c_eff = columns_q;
		if (rows_q == '0)
			r_eff = ROWS_W'(1);
		else if (rows_q > MAX_ROWS)
			r_eff = MAX_ROWS;
		else
			r_eff = rows_q;
	end

	// cursor
	assign col_sat  = ({1'b0, col_q} >= c_eff) ? COL_W'(c_eff - COLS_W'(1)) : col_q;
	assign row_sat  = ({1'b0, row_q} >= r_eff) ? ROW_W'(r_eff - ROWS_W'(1)) : row_q;
	assign row_inc  = {1'b0, row_sat} + ROWS_W'(1);
	assign row_wrap = row_inc >= r_eff;
	assign nr_row   = row_wrap ? ROW_W'(r_eff - ROWS_W'(1)) : row_inc[ROW_W-1:0];
	assign col_inc  = {1'b0, col_sat} + COLS_W'(1);
	assign col_wrap = col_inc >= c_eff;

	assign wr_sum = PROD_W'(row_sat) * PROD_W'(c_eff) + PROD_W'(col_sat);
	assign wr_pos = wr_sum[ADDR_W-1:0];

	always_comb begin
		col_d      = col_q;
		row_d      = row_q;
		scroll_req = 1'b0;
		chr_we     = 1'b0;
		if (cmd.exec) begin
			col_d = col_sat;
			row_d = row_sat;
			if (item_q.kind == KIND_PUT) begin
				case (item_q.char_code)
					CH_LF: begin
						col_d      = '0;
						row_d      = nr_row;
						scroll_req = row_wrap;
					end
					CH_CR: begin
						col_d = '0;
					end
					CH_BS: begin
						if (col_sat != '0)
							col_d = col_sat - COL_W'(1);
					end
					default: begin
						chr_we = 1'b1;
						if (col_wrap) begin
							col_d      = '0;
							row_d      = nr_row;
							scroll_req = row_wrap;
						end else begin
							col_d = col_inc[COL_W-1:0];
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			item_q <= req;
	end

	// sweep counter: clearing pass after reset, then scroll copy
	assign src   = ptr_q + CNT_W'(c_eff);
	assign issue = cmd.scroll_step && (ptr_q != total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			wv_s1 <= 1'b0;
		end else begin
			if (cmd.exec)
				ptr_q <= '0;
			else if (cmd.clr_step || issue)
				ptr_q <= ptr_q + CNT_W'(1);
			wv_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec)
			total_q <= CNT_W'(c_eff) * CNT_W'(r_eff);
		waddr_s1 <= ptr_q[ADDR_W-1:0];
		copy_s1  <= src < total_q;
	end

	assign sts.clear_last  = ptr_q == CNT_W'(MAX_CELLS - 1);
	assign sts.scroll_req  = scroll_req;
	assign sts.scroll_last = ptr_q == total_q;

	// cell store
	assign re    = issue || (cmd.exec && item_q.kind == KIND_READ);
	assign raddr = issue ? src[ADDR_W-1:0] : item_q.cell_address[ADDR_W-1:0];
	assign we    = cmd.clr_step || chr_we || wv_s1;

	always_comb begin
		if (cmd.clr_step) begin
			waddr = ptr_q[ADDR_W-1:0];
			wdata = BLANK_CELL;
		end else if (chr_we) begin
			waddr = wr_pos;
			wdata = {{(CELL_W-CHAR_W){1'b0}}, item_q.char_code} | TEXT_ATTRIBUTE;
		end else begin
			waddr = waddr_s1;
			wdata = copy_s1 ? rdata_q : BLANK_CELL;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	// result register
	assign pos_sum = PROD_W'(row_q) * PROD_W'(c_eff) + PROD_W'(col_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.cursor_position <= pos_sum[POS_W-1:0];
			rsp_q.cell_data       <= (item_q.kind == KIND_READ) ? rdata_q : '0;
		end
	end

	assign rsp = rsp_q;

endmodule

[src/tcw_ctrl.sv]
// ---------------------------------------------------------------------------
// tcw_ctrl
// Controller: clearing pass, item sequencing, scroll sweep and the
// handshakes of both channels.
// ---------------------------------------------------------------------------
module tcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  tcw_pkg::sts_t sts,
	output tcw_pkg::cmd_t cmd
);
	import tcw_pkg::*;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clear_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.scroll_req ? ST_SCROLL : ST_DONE;
			end
			ST_SCROLL: begin
				cmd.scroll_step = 1'b1;
				if (sts.scroll_last)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					req_stall    = 1'b0;
					if (req_valid) begin
						cmd.capture = 1'b1;
						state_d     = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[src/text_console_writer.sv]
// ---------------------------------------------------------------------------
// text_console_writer
// Text-mode console writer: cell store with cursor, line feed, return,
// backspace, wrap and scroll; read beats return one cell.
//
//  channel  dir  handshake              payload
//  req      in   req_valid / req_stall  req.kind, req.char_code, req.cell_address
//  rsp      out  rsp_valid / rsp_stall  rsp.cursor_position, rsp.cell_data
//  cfg      in   cfg_we                 cfg_index (0 columns, 1 rows), cfg_data
//
// after reset a clearing pass writes 4096 blank cells, one a cycle, before
// the first req beat is taken
// a beat passes through the EXEC and DONE states; a scroll adds the SCROLL
// state, which rewrites all columns*rows cells, one cell a cycle
// a stalled result is held in the output register; the next beat is taken
// while it waits and its result waits in turn
// ---------------------------------------------------------------------------
module text_console_writer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [tcw_pkg::COLS_W-1:0] cfg_data,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  tcw_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output tcw_pkg::rsp_t              rsp
);
	import tcw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

[src/tcw_chk.sv]
// ---------------------------------------------------------------------------
// tcw_chk
// Port checker for the text console writer, bound to the top level.
// ---------------------------------------------------------------------------
module tcw_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_stall,
	input logic                       rsp_valid,
	input logic                       rsp_stall,
	input tcw_pkg::rsp_t              rsp
);
	import tcw_pkg::*;

	logic req_beat;

	assign req_beat = req_valid && !req_stall;

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// no beat taken in the cycle after one was taken
	a_req_gap: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |=> req_stall)
		else $error("req beat taken in consecutive cycles");

	// clearing pass holds off req right after reset
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> req_stall)
		else $error("req taken before clearing pass");

	// a beat taken while a result waits stalled leaves that result in place
	a_rsp_keep: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && rsp_valid && rsp_stall |=> rsp_valid)
		else $error("waiting result lost");

endmodule

bind text_console_writer tcw_chk u_chk (.*);
